// ===== rtl/pl_pkg.sv =====
// Package for the positional list: request and status codes, cell operations
// and controller states. No dependencies.
package pl_pkg;

  localparam int unsigned CAPACITY_DEF = 16;

  localparam logic [1:0] REQ_INS = 2'd0;
  localparam logic [1:0] REQ_DEL = 2'd1;
  localparam logic [1:0] REQ_LOC = 2'd2;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INS,
    OP_DEL,
    OP_ROT
  } pl_op_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } pl_state_t;

endpackage

// ===== rtl/positional_list_insert_delete_find.sv =====
// Top level of the positional list: controller, result register and the row
// of pl_cell slots. Depends on pl_pkg and pl_cell.
//
// Use: one request beat on in_* (req_type, 1-based position, value) gives one
// result beat on out_* (status, found_position, length after the request).
// Both channels are valid/ready; a beat moves when valid and ready are high.
// Insert and delete shift the whole row of cells at once: the result is
// valid in the cycle after the request beat, and such requests may follow
// back to back. Refused requests and unused codes are answered likewise.
// Locate rotates the list once through the row, comparing the head cell
// with the key each cycle, and takes no new request until the result is
// registered. The rotation leaves the list in its original order.
// A request is taken while an earlier result still waits, provided that
// result leaves in the same cycle; a stalled receiver holds in_ready low.
// Reset (rst_n low, synchronous) empties the list; entry contents are not
// cleared and are never visible until written.
module positional_list_insert_delete_find #(
  parameter int unsigned CAPACITY = pl_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_req_type,
  input  logic [4:0]         in_position,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [4:0]         out_found_position,
  output logic [4:0]         out_length
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned WW = ((CW > 5) ? CW : 5) + 1;

  pl_pkg::pl_state_t state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]      fpos_r, fpos_nxt;
  logic signed [31:0] key_r, key_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic [4:0]         out_found_r, out_found_nxt;
  logic [4:0]         out_length_r, out_length_nxt;

  pl_pkg::pl_op_t     op;
  logic [CW-1:0]      slot;
  logic               accept;
  logic               out_free;
  logic [WW-1:0]      pos_w, cnt_w;
  logic               match;
  logic               scan_last;
  logic signed [31:0] cell_q [CAPACITY];

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == pl_pkg::S_IDLE) && out_free;
  assign accept    = in_valid && in_ready;
  assign pos_w     = WW'(in_position);
  assign cnt_w     = WW'(count_r);
  assign slot      = CW'(pos_w - WW'(1));
  assign match     = (cell_q[0] == key_r);
  assign scan_last = (idx_r == count_r - CW'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pl_pkg::S_IDLE: begin
        if (accept && in_req_type == pl_pkg::REQ_LOC && count_r != '0) begin
          state_nxt = pl_pkg::S_SCAN;
        end
      end
      pl_pkg::S_SCAN: begin
        if (scan_last) begin
          state_nxt = pl_pkg::S_IDLE;
        end
      end
      default: state_nxt = pl_pkg::S_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    op             = pl_pkg::OP_HOLD;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    fpos_nxt       = fpos_r;
    key_nxt        = key_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_length_nxt = out_length_r;
    unique case (state_r)
      pl_pkg::S_IDLE: begin
        if (accept) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pl_pkg::ST_DONE;
          out_found_nxt  = '0;
          out_length_nxt = 5'(count_r);
          priority if (in_req_type == pl_pkg::REQ_INS) begin
            if (cnt_w >= WW'(CAPACITY)) begin
              out_status_nxt = pl_pkg::ST_FULL;
            end else if (pos_w == '0 || pos_w > cnt_w + WW'(1)) begin
              out_status_nxt = pl_pkg::ST_BADPOS;
            end else begin
              op             = pl_pkg::OP_INS;
              count_nxt      = count_r + CW'(1);
              out_length_nxt = 5'(count_nxt);
            end
          end else if (in_req_type == pl_pkg::REQ_DEL) begin
            if (count_r == '0) begin
              out_status_nxt = pl_pkg::ST_EMPTY;
            end else if (pos_w == '0 || pos_w > cnt_w) begin
              out_status_nxt = pl_pkg::ST_BADPOS;
            end else begin
              op             = pl_pkg::OP_DEL;
              count_nxt      = count_r - CW'(1);
              out_length_nxt = 5'(count_nxt);
            end
          end else if (in_req_type == pl_pkg::REQ_LOC) begin
            idx_nxt  = '0;
            fpos_nxt = '0;
            key_nxt  = in_value;
            if (count_r != '0) begin
              out_valid_nxt = 1'b0;
            end
          end else begin
            out_status_nxt = pl_pkg::ST_BADPOS;
          end
        end
      end
      pl_pkg::S_SCAN: begin
        op      = pl_pkg::OP_ROT;
        idx_nxt = idx_r + CW'(1);
        if (fpos_r == '0 && match) begin
          fpos_nxt = idx_r + CW'(1);
        end
        if (scan_last) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pl_pkg::ST_DONE;
          out_found_nxt  = 5'(fpos_nxt);
          out_length_nxt = 5'(count_r);
        end
      end
      default: op = pl_pkg::OP_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pl_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    fpos_r       <= fpos_nxt;
    key_r        <= key_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_length_r <= out_length_nxt;
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic signed [31:0] prev_d;
    logic signed [31:0] next_d;
    if (k == 0) begin : g_first
      assign prev_d = '0;
    end else begin : g_prev
      assign prev_d = cell_q[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign next_d = '0;
    end else begin : g_next
      assign next_d = cell_q[k+1];
    end
    pl_cell #(
      .INDEX (k),
      .CW    (CW)
    ) u_cell (
      .clk    (clk),
      .op     (op),
      .slot   (slot),
      .cnt    (count_r),
      .prev_d (prev_d),
      .next_d (next_d),
      .head_d (cell_q[0]),
      .val    (in_value),
      .data   (cell_q[k])
    );
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_position = out_found_r;
  assign out_length         = out_length_r;

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, count_r} <= (CW+1)'(CAPACITY))
    else $error("list length beyond capacity");

  a_scan_idx: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pl_pkg::S_SCAN |-> idx_r < count_r)
    else $error("scan index past list end");

  a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_req_type == pl_pkg::REQ_INS && {1'b0, count_r} == (CW+1)'(CAPACITY)
    |=> out_valid && out_status == pl_pkg::ST_FULL && $stable(count_r))
    else $error("insert into full list not refused");

  a_locate_scan: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_req_type == pl_pkg::REQ_LOC && count_r != '0
    |=> state_r == pl_pkg::S_SCAN && !out_valid)
    else $error("locate did not start a scan");

  a_scan_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pl_pkg::S_SCAN |=> $stable(count_r))
    else $error("length changed during scan");
`endif

endmodule

// ===== rtl/pl_cell.sv =====
// One list slot: holds an entry and takes its neighbour's, the new value or
// the head entry as the list operation requires. Depends on pl_pkg.
module pl_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned CW    = 5
) (
  input  logic                clk,
  input  pl_pkg::pl_op_t      op,
  input  logic [CW-1:0]       slot,
  input  logic [CW-1:0]       cnt,
  input  logic signed [31:0]  prev_d,
  input  logic signed [31:0]  next_d,
  input  logic signed [31:0]  head_d,
  input  logic signed [31:0]  val,
  output logic signed [31:0]  data
);

  localparam logic [CW:0] K  = (CW+1)'(INDEX);
  localparam logic [CW:0] K1 = (CW+1)'(INDEX + 1);

  logic signed [31:0] data_r;
  logic signed [31:0] data_nxt;
  logic [CW:0]        slot_w;
  logic [CW:0]        cnt_w;

  assign slot_w = {1'b0, slot};
  assign cnt_w  = {1'b0, cnt};

  always_comb begin
    data_nxt = data_r;
    unique case (op)
      pl_pkg::OP_INS: begin
        if (K == slot_w) begin
          data_nxt = val;
        end else if (K > slot_w && K <= cnt_w) begin
          data_nxt = prev_d;
        end
      end
      pl_pkg::OP_DEL: begin
        if (K >= slot_w && K1 < cnt_w) begin
          data_nxt = next_d;
        end
      end
      pl_pkg::OP_ROT: begin
        if (K1 == cnt_w) begin
          data_nxt = head_d;
        end else if (K1 < cnt_w) begin
          data_nxt = next_d;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for positional_list_insert_delete_find: directed and random list
// requests, each result checked against a behavioural list model. Uses pl_pkg.
module testbench;

  localparam int unsigned LIST_DEPTH = pl_pkg::CAPACITY_DEF;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] found_position;
    logic [4:0] length;
  } list_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_req_type = pl_pkg::REQ_INS;
  logic [4:0]         in_position = '0;
  logic signed [31:0] in_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_status;
  logic [4:0]         out_found_position;
  logic [4:0]         out_length;

  logic [31:0]  list_store [LIST_DEPTH];
  int           list_len = 0;
  list_result_t pending_results [$];
  int           fail_count = 0;
  bit           idle_on = 1'b1;
  int           stall_left = 0;

  positional_list_insert_delete_find dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_found_position (out_found_position),
    .out_length         (out_length)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // list model: applies one request, returns the result it gives
  function automatic list_result_t apply_request(logic [1:0] req, logic [4:0] pos_in,
                                                 logic [31:0] val);
    list_result_t res;
    int pos;
    int k;
    pos = pos_in;
    res = '{status: pl_pkg::ST_BADPOS, found_position: 5'd0, length: 5'd0};
    case (req)
      pl_pkg::REQ_INS: begin
        if (list_len >= LIST_DEPTH) begin
          res.status = pl_pkg::ST_FULL;
        end else if (pos >= 1 && pos <= list_len + 1) begin
          for (k = list_len; k > pos - 1; k--) list_store[k] = list_store[k - 1];
          list_store[pos - 1] = val;
          list_len++;
          res.status = pl_pkg::ST_DONE;
        end
      end
      pl_pkg::REQ_DEL: begin
        if (list_len == 0) begin
          res.status = pl_pkg::ST_EMPTY;
        end else if (pos >= 1 && pos <= list_len) begin
          for (k = pos - 1; k + 1 < list_len; k++) list_store[k] = list_store[k + 1];
          list_len--;
          res.status = pl_pkg::ST_DONE;
        end
      end
      pl_pkg::REQ_LOC: begin
        res.status = pl_pkg::ST_DONE;
        for (k = list_len - 1; k >= 0; k--)
          if (list_store[k] == val) res.found_position = 5'(k + 1);
      end
      default: ;
    endcase
    res.length = 5'(list_len);
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    fail_count++;
    $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result beat", 1, 0);
      end else begin
        list_result_t want;
        want = pending_results.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", out_status, want.status);
        if (out_found_position !== want.found_position)
          report_mismatch("found_position", out_found_position, want.found_position);
        if (out_length !== want.length)
          report_mismatch("length", out_length, want.length);
      end
    end
  end

  // receiver back-pressure in short bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 7) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_request(logic [1:0] req, logic [4:0] pos, logic [31:0] val);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_position <= pos;
    in_value    <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(apply_request(req, pos, val));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_list();
    send_request(pl_pkg::REQ_LOC, 5'd0, 32'd0);
    send_request(pl_pkg::REQ_DEL, 5'd0, 32'd0);
    send_request(pl_pkg::REQ_INS, 5'd0, 32'd1);
    send_request(pl_pkg::REQ_INS, 5'd2, 32'd1);
  endtask

  task automatic test_fill_to_full();
    logic [31:0] vals [4];
    int n;
    vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'd5};
    for (n = 0; n < LIST_DEPTH; n++)
      send_request(pl_pkg::REQ_INS, (n % 3 == 0) ? 5'd1 : 5'(n / 2 + 1),
                   (n < 4) ? vals[n] : ((n % 5 == 0) ? 32'd5 : $urandom));
    send_request(pl_pkg::REQ_INS, 5'd31, 32'd9);
  endtask

  task automatic test_locate();
    send_request(pl_pkg::REQ_LOC, 5'd31, 32'd5);
    send_request(pl_pkg::REQ_LOC, 5'd0, 32'h8000_0000);
    send_request(pl_pkg::REQ_LOC, 5'd3, 32'h1234_5678);
  endtask

  task automatic test_delete_edges();
    send_request(pl_pkg::REQ_DEL, 5'd0, 32'd0);
    send_request(pl_pkg::REQ_DEL, 5'd31, 32'd0);
    send_request(pl_pkg::REQ_DEL, 5'(list_len), 32'd0);
    send_request(pl_pkg::REQ_DEL, 5'd1, 32'hFFFF_FFFF);
  endtask

  task automatic test_unused_code();
    send_request(REQ_UNUSED, 5'd1, 32'd0);
  endtask

  task automatic test_random(int items);
    int n;
    int r;
    int grow;
    logic [1:0] req;
    logic [4:0] pos;
    logic [31:0] val;
    grow = 1;
    for (n = 0; n < items; n++) begin
      if (n % 40 == 0) grow = $urandom_range(0, 1);
      if (n == items / 2) wait_for_results();
      if (n == items - 80) idle_on = 1'b0;
      r = $urandom_range(0, 99);
      val = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 3)) : $urandom;
      if (r < (grow ? 50 : 25)) begin
        req = pl_pkg::REQ_INS;
        pos = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                          : 5'($urandom_range(1, list_len + 1));
      end else if (r < 75) begin
        req = pl_pkg::REQ_DEL;
        pos = ($urandom_range(0, 9) == 0 || list_len == 0) ? 5'($urandom_range(0, 31))
                                                          : 5'($urandom_range(1, list_len));
      end else if (r < 96) begin
        req = pl_pkg::REQ_LOC;
        pos = 5'($urandom_range(0, 31));
        if (list_len > 0 && $urandom_range(0, 2) != 0)
          val = list_store[$urandom_range(0, list_len - 1)];
      end else begin
        req = REQ_UNUSED;
        pos = 5'($urandom_range(0, 31));
      end
      send_request(req, pos, val);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_fill_to_full();
    test_locate();
    test_delete_edges();
    test_unused_code();
    test_random(400);
    wait_for_results();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      if (pending_results.size() != 0)
        report_mismatch("results outstanding", pending_results.size(), 0);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
